@@ hw/rtl/dnls_pkg.sv @@
// ----------------------------------------------------------------------------
// dnls_pkg: shared types and constants of the day/night luma switch
// Holds the frame size limit, the luma weights, the register map, the reset
// values of the control registers and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package dnls_pkg;

   // Largest number of pixels that one frame may carry.
   localparam int MAX_PIXELS = 32768;

   // Width of the pixel counter: it must hold MAX_PIXELS itself.
   localparam int COUNT_W = $clog2(MAX_PIXELS + 1);

   // Width of the luma accumulator and of the dividend that the mean uses.
   localparam int SUM_W = 32;
   localparam int DIV_W = SUM_W - 8;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Luma weights of the red, green and blue components.
   localparam logic [15:0] WEIGHT_R = 16'd77;
   localparam logic [15:0] WEIGHT_G = 16'd150;
   localparam logic [15:0] WEIGHT_B = 16'd29;

   // Largest mean luma that is reported.
   localparam logic [7:0] LUMA_MAX = 8'd255;

   // Register map: index of each register, byte address is four times it.
   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_DARK_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_BRIGHT_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_CONFIRM_NEEDED = 3'd2;
   localparam logic [2:0] REG_AUTO_ENABLE = 3'd3;
   localparam logic [2:0] REG_SENSOR_BW_CAPABLE = 3'd4;

   // Reset values of the control registers.
   localparam logic [7:0] DARK_THRESHOLD_RST = 8'd40;
   localparam logic [7:0] BRIGHT_THRESHOLD_RST = 8'd65;
   localparam logic [3:0] CONFIRM_NEEDED_RST = 4'd2;

   // Input opcodes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Control register contents handed to the sequencer.
   typedef struct packed {
      logic [7:0] dark_threshold;
      logic [7:0] bright_threshold;
      logic [3:0] confirm_needed;
      logic       auto_enable;
      logic       sensor_bw_capable;
   } cfg_type;

   // Pixel accumulator contents at the end of a frame.
   typedef struct packed {
      logic [SUM_W-1:0]   luma_sum;
      logic [COUNT_W-1:0] pixel_count;
      logic               frame_too_big;
   } frame_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/dnls_req_if.sv @@
// ----------------------------------------------------------------------------
// dnls_req_if: input channel of the day/night luma switch
// Carries pixel transactions and sample ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnls_req_if;

   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_ok;

   modport source (
      output valid, opcode, red, green, blue, frame_ok,
      input  ready
   );

   modport sink (
      input  valid, opcode, red, green, blue, frame_ok,
      output ready
   );

endinterface

`default_nettype wire

@@ hw/rtl/dnls_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dnls_rsp_if: result channel of the day/night luma switch
// Carries one result transaction per sample tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnls_rsp_if;

   logic              valid;
   logic              ready;
   logic [7:0]        luma;
   logic              sampled;
   logic              effect_bw;
   logic              command_valid;
   logic              command_bw;
   logic              gray_supported;
   logic [31:0]       sample_count;
   logic [31:0]       switch_count;
   logic signed [4:0] confirm_level;

   modport source (
      output valid, luma, sampled, effect_bw, command_valid, command_bw,
             gray_supported, sample_count, switch_count, confirm_level,
      input  ready
   );

   modport sink (
      input  valid, luma, sampled, effect_bw, command_valid, command_bw,
             gray_supported, sample_count, switch_count, confirm_level,
      output ready
   );

endinterface

`default_nettype wire

@@ hw/rtl/dnls_csr.sv @@
// ----------------------------------------------------------------------------
// dnls_csr: control registers of the day/night luma switch
// APB-style register file with zero wait states; registers sit at word
// addresses in the order dark, bright, confirm, auto enable, sensor capable.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [dnls_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   output dnls_pkg::cfg_type               cfg
);

   logic [7:0] dark_ff;
   logic [7:0] bright_ff;
   logic [3:0] confirm_ff;
   logic       auto_ff;
   logic       capable_ff;
   logic [2:0] index;
   logic       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;

   // Register writes; an address beyond the map is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff    <= dnls_pkg::DARK_THRESHOLD_RST;
         bright_ff  <= dnls_pkg::BRIGHT_THRESHOLD_RST;
         confirm_ff <= dnls_pkg::CONFIRM_NEEDED_RST;
         auto_ff    <= 1'b1;
         capable_ff <= 1'b1;
      end else if (wr_en) begin
         unique case (index)
            dnls_pkg::REG_DARK_THRESHOLD:    dark_ff    <= pwdata[7:0];
            dnls_pkg::REG_BRIGHT_THRESHOLD:  bright_ff  <= pwdata[7:0];
            dnls_pkg::REG_CONFIRM_NEEDED:    confirm_ff <= pwdata[3:0];
            dnls_pkg::REG_AUTO_ENABLE:       auto_ff    <= pwdata[0];
            dnls_pkg::REG_SENSOR_BW_CAPABLE: capable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read data multiplexer.
   always_comb begin
      unique case (index)
         dnls_pkg::REG_DARK_THRESHOLD:    prdata = {24'd0, dark_ff};
         dnls_pkg::REG_BRIGHT_THRESHOLD:  prdata = {24'd0, bright_ff};
         dnls_pkg::REG_CONFIRM_NEEDED:    prdata = {28'd0, confirm_ff};
         dnls_pkg::REG_AUTO_ENABLE:       prdata = {31'd0, auto_ff};
         dnls_pkg::REG_SENSOR_BW_CAPABLE: prdata = {31'd0, capable_ff};
         default:                         prdata = 32'd0;
      endcase
   end

   assign cfg.dark_threshold    = dark_ff;
   assign cfg.bright_threshold  = bright_ff;
   assign cfg.confirm_needed    = confirm_ff;
   assign cfg.auto_enable       = auto_ff;
   assign cfg.sensor_bw_capable = capable_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dnls_accum.sv @@
// ----------------------------------------------------------------------------
// dnls_accum: pixel luma accumulator
// Sums 77R + 150G + 29B over the pixels of a frame and counts them; pixels
// past the frame size limit mark the frame as oversized and are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_accum (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pixel_fire,
   input  wire logic          frame_clear,
   input  wire logic [7:0]    red,
   input  wire logic [7:0]    green,
   input  wire logic [7:0]    blue,
   output dnls_pkg::frame_type frame
);

   logic [dnls_pkg::SUM_W-1:0]   sum_ff;
   logic [dnls_pkg::COUNT_W-1:0] count_ff;
   logic                         too_big_ff;
   logic [15:0]                  weight;
   logic                         full;

   // Weighted luma of one pixel; fits 16 bits.
   assign weight = 16'(red) * dnls_pkg::WEIGHT_R
                 + 16'(green) * dnls_pkg::WEIGHT_G
                 + 16'(blue) * dnls_pkg::WEIGHT_B;

   assign full = (count_ff >= dnls_pkg::COUNT_W'(dnls_pkg::MAX_PIXELS));

   // Accumulate pixels; a tick clears the frame after it is handed over.
   always_ff @(posedge clock) begin
      if (reset || frame_clear) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         too_big_ff <= 1'b0;
      end else if (pixel_fire) begin
         if (full) begin
            too_big_ff <= 1'b1;
         end else begin
            sum_ff   <= sum_ff + dnls_pkg::SUM_W'(weight);
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign frame.luma_sum      = sum_ff;
   assign frame.pixel_count   = count_ff;
   assign frame.frame_too_big = too_big_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dnls_div.sv @@
// ----------------------------------------------------------------------------
// dnls_div: serial restoring divider
// Divides the scaled luma sum by the pixel count, one quotient bit per cycle,
// with a single shared subtract and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [dnls_pkg::DIV_W-1:0]   dividend,
   input  wire logic [dnls_pkg::COUNT_W-1:0] divisor,
   output logic                              done,
   output logic      [dnls_pkg::DIV_W-1:0]   quotient
);

   localparam int RemW = dnls_pkg::COUNT_W;

   logic [RemW-1:0]                rem_ff;
   logic [dnls_pkg::DIV_W-1:0]     quo_ff;
   logic [RemW-1:0]                div_ff;
   logic [dnls_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [RemW:0]                  shifted;
   logic [RemW+1:0]                diff;
   logic                           fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign shifted = {rem_ff, quo_ff[dnls_pkg::DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = !diff[RemW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == dnls_pkg::DIV_CNT_W'(dnls_pkg::DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Datapath of the divider; no reset needed.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[RemW-1:0] : shifted[RemW-1:0];
         quo_ff <= {quo_ff[dnls_pkg::DIV_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dnls_ctrl.sv @@
// ----------------------------------------------------------------------------
// dnls_ctrl: sequencer and day/night decision
// Takes transactions from the input channel, runs the divider on a sampling
// tick, updates the confirm counter and effect state, and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dnls_pkg::cfg_type            cfg,
   input  wire dnls_pkg::frame_type          frame,
   dnls_req_if.sink                          req_bus,
   dnls_rsp_if.source                        rsp_bus,
   output logic                              pixel_fire,
   output logic                              frame_clear,
   output logic                              div_start,
   output logic      [dnls_pkg::DIV_W-1:0]   div_dividend,
   output logic      [dnls_pkg::COUNT_W-1:0] div_divisor,
   input  wire logic                         div_done,
   input  wire logic [dnls_pkg::DIV_W-1:0]   div_quotient
);

   dnls_pkg::state_type state_ff, state_in;

   // Decision state.
   logic signed [4:0] cc_ff, cc_in;
   logic              eff_ff, eff_in;
   logic              probed_ff, probed_in;
   logic              bwsup_ff, bwsup_in;
   logic              applied_ff, applied_in;
   logic [7:0]        last_luma_ff, last_luma_in;
   logic [31:0]       samples_ff, samples_in;
   logic [31:0]       switches_ff, switches_in;
   logic              sample_go_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic [7:0]        rsp_luma_ff;
   logic              rsp_sampled_ff;
   logic              rsp_cmd_valid_ff;
   logic              rsp_cmd_bw_ff;

   logic              req_fire;
   logic              tick_fire;
   logic              sample_go;
   logic              finish_load;
   logic              sampled;
   logic              cmd_valid;
   logic              cmd_bw;
   logic [7:0]        luma;
   logic signed [5:0] cc_ext;
   logic signed [5:0] cc_step;
   logic signed [5:0] need;
   logic              want;

   assign req_bus.ready = (state_ff == dnls_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign pixel_fire    = req_fire && (req_bus.opcode == dnls_pkg::OP_PIXEL);
   assign tick_fire     = req_fire && (req_bus.opcode == dnls_pkg::OP_TICK);
   assign frame_clear   = tick_fire;

   // A tick needs the divider only when it will take a sample.
   assign sample_go    = cfg.auto_enable && req_bus.frame_ok && !frame.frame_too_big;
   assign div_start    = tick_fire && sample_go;
   assign div_dividend = frame.luma_sum[dnls_pkg::SUM_W-1:8];
   assign div_divisor  = (frame.pixel_count == '0) ? dnls_pkg::COUNT_W'(1)
                                                   : frame.pixel_count;

   // The finished tick is registered once the result slot is free.
   assign finish_load = (state_ff == dnls_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dnls_pkg::ST_IDLE: begin
            if (tick_fire) begin
               state_in = sample_go ? dnls_pkg::ST_DIV : dnls_pkg::ST_FINISH;
            end
         end
         dnls_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = dnls_pkg::ST_FINISH;
            end
         end
         dnls_pkg::ST_FINISH: begin
            if (finish_load) begin
               state_in = dnls_pkg::ST_IDLE;
            end
         end
         default: state_in = dnls_pkg::ST_IDLE;
      endcase
   end

   // Mean luma, saturated to eight bits.
   assign luma = (div_quotient[dnls_pkg::DIV_W-1:8] != '0) ? dnls_pkg::LUMA_MAX
                                                          : div_quotient[7:0];

   // Day/night decision at the end of a tick.
   always_comb begin
      cc_in        = cc_ff;
      eff_in       = eff_ff;
      probed_in    = probed_ff;
      bwsup_in     = bwsup_ff;
      applied_in   = applied_ff;
      last_luma_in = last_luma_ff;
      samples_in   = samples_ff;
      switches_in  = switches_ff;
      sampled      = 1'b0;
      cmd_valid    = 1'b0;
      cmd_bw       = 1'b0;
      cc_ext       = {cc_ff[4], cc_ff};
      cc_step      = cc_ext;
      need         = (cfg.confirm_needed == 4'd0) ? 6'sd1
                                                  : $signed({2'b00, cfg.confirm_needed});
      want         = eff_ff;

      if (!cfg.auto_enable) begin
         // Manual mode restores colour once if the automatic path changed it.
         if (applied_ff) begin
            cmd_valid  = 1'b1;
            applied_in = 1'b0;
            eff_in     = 1'b0;
            cc_in      = '0;
         end
      end else if (sample_go_ff) begin
         sampled      = 1'b1;
         last_luma_in = luma;
         samples_in   = samples_ff + 32'd1;

         if (luma < cfg.dark_threshold) begin
            cc_step = (cc_ext > 6'sd0) ? -6'sd1 : cc_ext - 6'sd1;
         end else if (luma > cfg.bright_threshold) begin
            cc_step = (cc_ext < 6'sd0) ? 6'sd1 : cc_ext + 6'sd1;
         end else begin
            cc_step = 6'sd0;
         end

         if (cc_step <= -need) begin
            want    = 1'b1;
            cc_step = 6'sd0;
         end else if (cc_step >= need) begin
            want    = 1'b0;
            cc_step = 6'sd0;
         end
         cc_in = cc_step[4:0];

         // Send the effect command; an incapable sensor falls back to colour.
         if ((want != eff_ff) || !probed_ff) begin
            cmd_valid = 1'b1;
            cmd_bw    = want;
            if (!cfg.sensor_bw_capable) begin
               bwsup_in   = 1'b0;
               eff_in     = 1'b0;
               applied_in = 1'b0;
            end else begin
               probed_in   = 1'b1;
               bwsup_in    = 1'b1;
               eff_in      = want;
               applied_in  = 1'b1;
               switches_in = switches_ff + 32'd1;
            end
         end
      end
   end

   // Control and decision state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnls_pkg::ST_IDLE;
         cc_ff        <= '0;
         eff_ff       <= 1'b0;
         probed_ff    <= 1'b0;
         bwsup_ff     <= 1'b1;
         applied_ff   <= 1'b0;
         last_luma_ff <= '0;
         samples_ff   <= '0;
         switches_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish_load) begin
            cc_ff        <= cc_in;
            eff_ff       <= eff_in;
            probed_ff    <= probed_in;
            bwsup_ff     <= bwsup_in;
            applied_ff   <= applied_in;
            last_luma_ff <= last_luma_in;
            samples_ff   <= samples_in;
            switches_ff  <= switches_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Tick attributes and result payload.
   always_ff @(posedge clock) begin
      if (tick_fire) begin
         sample_go_ff <= sample_go;
      end
      if (finish_load) begin
         rsp_luma_ff      <= last_luma_in;
         rsp_sampled_ff   <= sampled;
         rsp_cmd_valid_ff <= cmd_valid;
         rsp_cmd_bw_ff    <= cmd_bw;
      end
   end

   // Counters and flags in the result mirror the committed state.
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.luma           = rsp_luma_ff;
   assign rsp_bus.sampled        = rsp_sampled_ff;
   assign rsp_bus.effect_bw      = eff_ff;
   assign rsp_bus.command_valid  = rsp_cmd_valid_ff;
   assign rsp_bus.command_bw     = rsp_cmd_bw_ff;
   assign rsp_bus.gray_supported = bwsup_ff;
   assign rsp_bus.sample_count   = samples_ff;
   assign rsp_bus.switch_count   = switches_ff;
   assign rsp_bus.confirm_level  = cc_ff;

endmodule

`default_nettype wire

@@ hw/rtl/day_night_luma_switch_top.sv @@
// ----------------------------------------------------------------------------
// day_night_luma_switch_top: day/night effect switch driven by mean luma
// Accumulates pixel luma over a frame and, on each sample tick, decides
// whether the sensor should run the black-and-white or the colour effect.
// ----------------------------------------------------------------------------
// Usage:
// The req_bus channel carries pixel transactions (opcode 0) and sample ticks
// (opcode 1); the rsp_bus channel returns one result transaction per tick
// and nothing for pixels. Pixels are taken one per cycle while the block is
// idle. A tick that takes a sample runs the serial divider for the mean
// luma, one quotient bit per cycle over 24 bits, then the finish state and
// the result register; a tick that takes no sample (manual mode, failed or
// oversized frame) goes straight to the finish state and result register.
// req_bus.ready stays low from a tick until its result is registered.
// A stalled receiver holds the result register; pixels of the next frame are
// still taken meanwhile, and the following tick is taken but then keeps
// req_bus.ready low until the result slot frees.
// The user must write control registers on the APB-style port only while
// the block is idle; the block itself does not enforce it. Reset clears the
// frame, the counters and the confirm counter, sets colour mode with the
// sensor assumed capable, and loads register defaults. Both counters and
// the decision state are visible in every result.
// ----------------------------------------------------------------------------
`default_nettype none

module day_night_luma_switch_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dnls_req_if.sink                        req_bus,
   dnls_rsp_if.source                      rsp_bus,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [dnls_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready
);

   dnls_pkg::cfg_type              cfg;
   dnls_pkg::frame_type            frame;
   logic                           pixel_fire;
   logic                           frame_clear;
   logic                           div_start;
   logic [dnls_pkg::DIV_W-1:0]     div_dividend;
   logic [dnls_pkg::COUNT_W-1:0]   div_divisor;
   logic                           div_done;
   logic [dnls_pkg::DIV_W-1:0]     div_quotient;

   // Control registers.
   dnls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Frame accumulator.
   dnls_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .pixel_fire  (pixel_fire),
      .frame_clear (frame_clear),
      .red         (req_bus.red),
      .green       (req_bus.green),
      .blue        (req_bus.blue),
      .frame       (frame)
   );

   // Serial divider for the mean luma.
   dnls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer and decision logic.
   dnls_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .frame        (frame),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .pixel_fire   (pixel_fire),
      .frame_clear  (frame_clear),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

endmodule

`default_nettype wire

@@ hw/rtl/dnls_checker.sv @@
// ----------------------------------------------------------------------------
// dnls_checker: port-level assertions of the day/night luma switch
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_opcode,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_effect_bw,
   input wire logic              rsp_command_valid,
   input wire logic              rsp_command_bw,
   input wire logic              rsp_gray_supported,
   input wire logic signed [4:0] rsp_confirm_level
);

   // A pending result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // In the cycle after a tick is taken the block is busy.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode |=> !req_ready)
      else $error("input taken right after a tick");

   // A black-and-white command is always a sent command.
   a_cmd_bw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_bw |-> rsp_command_valid)
      else $error("command effect without a command");

   // Black and white is only in effect on a sensor that supports it.
   a_bw_sup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_effect_bw |-> rsp_gray_supported)
      else $error("black and white on an unsupported sensor");

   // The confirm counter never reaches the most negative code.
   a_cc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_confirm_level != -5'sd16)
      else $error("confirm counter out of range");

endmodule

bind day_night_luma_switch_top dnls_checker u_dnls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_opcode         (req_bus.opcode),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_effect_bw      (rsp_bus.effect_bw),
   .rsp_command_valid  (rsp_bus.command_valid),
   .rsp_command_bw     (rsp_bus.command_bw),
   .rsp_gray_supported (rsp_bus.gray_supported),
   .rsp_confirm_level  (rsp_bus.confirm_level)
);

`default_nettype wire

@@ bench/tb_day_night_luma_switch_top.sv @@
// ----------------------------------------------------------------------------
// tb_day_night_luma_switch_top: self-checking bench of the day/night switch
// Streams frames of pixels and sample ticks into the block and checks every
// result transaction against a cycle-free model of the luma average, the
// confirm counter and the effect command logic. A short table of directed
// rows comes first, then random frames under several register settings and
// three patterns of idling on both channels. Register writes are read back
// on the control port.
// ----------------------------------------------------------------------------
module tb_day_night_luma_switch_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int BLOCKS_PER_PHASE = 4;
   localparam int ITEMS_PER_BLOCK = 118;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_ok;
   } luma_req_type;

   typedef struct packed {
      logic [7:0]        luma;
      logic              sampled;
      logic              effect_bw;
      logic              command_valid;
      logic              command_bw;
      logic              gray_supported;
      logic [31:0]       sample_count;
      logic [31:0]       switch_count;
      logic signed [4:0] confirm_level;
   } tick_result_type;

   typedef enum logic [1:0] {ROW_PIXEL, ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [7:0]      csr_value;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic            frame_ok;
      logic            typed;
      tick_result_type want;
   } stim_row_type;

   localparam tick_result_type NO_RESULT = '0;

   // First sample after reset: dark, and the colour effect is probed once.
   localparam tick_result_type FIRST_TICK = '{
      luma: 8'd0, sampled: 1'b1, effect_bw: 1'b0, command_valid: 1'b1,
      command_bw: 1'b0, gray_supported: 1'b1, sample_count: 32'd1,
      switch_count: 32'd1, confirm_level: -5'sd1};
   // Full white frame: the counter flips to the bright side.
   localparam tick_result_type WHITE_TICK = '{
      luma: 8'd255, sampled: 1'b1, effect_bw: 1'b0, command_valid: 1'b0,
      command_bw: 1'b0, gray_supported: 1'b1, sample_count: 32'd2,
      switch_count: 32'd1, confirm_level: 5'sd1};
   // First black frame after the white one.
   localparam tick_result_type BLACK_TICK = '{
      luma: 8'd0, sampled: 1'b1, effect_bw: 1'b0, command_valid: 1'b0,
      command_bw: 1'b0, gray_supported: 1'b1, sample_count: 32'd3,
      switch_count: 32'd1, confirm_level: -5'sd1};
   // Second black frame confirms the switch to black and white.
   localparam tick_result_type BW_SWITCH_TICK = '{
      luma: 8'd0, sampled: 1'b1, effect_bw: 1'b1, command_valid: 1'b1,
      command_bw: 1'b1, gray_supported: 1'b1, sample_count: 32'd4,
      switch_count: 32'd2, confirm_level: 5'sd0};
   // A failed frame takes no sample and leaves everything as it was.
   localparam tick_result_type FAILED_TICK = '{
      luma: 8'd0, sampled: 1'b0, effect_bw: 1'b1, command_valid: 1'b0,
      command_bw: 1'b0, gray_supported: 1'b1, sample_count: 32'd4,
      switch_count: 32'd2, confirm_level: 5'sd0};

   // Directed rows: CSR rows write one register, the others are transactions.
   stim_row_type directed_rows [34] = '{
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, FIRST_TICK},
      '{ROW_PIXEL, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, WHITE_TICK},
      '{ROW_PIXEL, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, BLACK_TICK},
      '{ROW_PIXEL, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, BW_SWITCH_TICK},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, FAILED_TICK},
      '{ROW_PIXEL, '0, '0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_AUTO_ENABLE, 8'd0,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd200, 8'd200, 8'd200, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_AUTO_ENABLE, 8'd1,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_SENSOR_BW_CAPABLE, 8'd0,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_CONFIRM_NEEDED, 8'd0,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd10, 8'd20, 8'd30, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_SENSOR_BW_CAPABLE, 8'd1,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_DARK_THRESHOLD, 8'd255,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_BRIGHT_THRESHOLD, 8'd0,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_DARK_THRESHOLD, 8'd0,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_BRIGHT_THRESHOLD, 8'd255,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CSR, dnls_pkg::REG_CONFIRM_NEEDED, 8'd15,
        8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_PIXEL, '0, '0, 8'd128, 8'd64, 8'd32, 1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RESULT}
   };

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [dnls_pkg::ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dnls_req_if req_bus();
   dnls_rsp_if rsp_bus();

   day_night_luma_switch_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the control registers.
   logic [7:0] cfg_dark;
   logic [7:0] cfg_bright;
   logic [3:0] cfg_confirm;
   logic       cfg_auto;
   logic       cfg_capable;

   // State of the switch as the bench sees it.
   logic [31:0] luma_acc;
   int unsigned frame_pixels;
   bit          frame_oversized;
   int          confirm_ctr;
   bit          bw_active;
   bit          effect_probed;
   bit          bw_believed;
   bit          auto_owned;
   logic [7:0]  last_mean;
   logic [31:0] samples_done;
   logic [31:0] effects_applied;

   tick_result_type tick_results_due [$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int unsigned     quiet_cycles = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One line per mismatch; the count decides the verdict.
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Advances the bench's copy of the switch by one transaction. Returns 1 when
   // the transaction is a tick, with the result it produces.
   function automatic bit step_switch(input luma_req_type it, output tick_result_type res);
      logic [31:0] mean;
      int          need;
      bit          want_bw;
      res = '0;
      if (it.opcode == dnls_pkg::OP_PIXEL) begin
         if (frame_pixels >= dnls_pkg::MAX_PIXELS) begin
            frame_oversized = 1'b1;
         end else begin
            luma_acc = luma_acc + 32'(it.red) * 32'd77 + 32'(it.green) * 32'd150
                       + 32'(it.blue) * 32'd29;
            frame_pixels++;
         end
         return 1'b0;
      end

      if (!cfg_auto) begin
         // Manual mode hands the sensor back to colour once.
         if (auto_owned) begin
            res.command_valid = 1'b1;
            auto_owned = 1'b0;
            bw_active = 1'b0;
            confirm_ctr = 0;
         end
      end else if (it.frame_ok && !frame_oversized) begin
         mean = (luma_acc >> 8) / ((frame_pixels != 0) ? frame_pixels : 1);
         if (mean > 255) begin
            mean = 255;
         end
         need = (cfg_confirm != 0) ? int'(cfg_confirm) : 1;
         want_bw = bw_active;
         res.sampled = 1'b1;
         last_mean = mean[7:0];
         samples_done++;

         // Dark is tested first; the band between thresholds clears the count.
         if (mean < cfg_dark) begin
            confirm_ctr = (confirm_ctr > 0) ? -1 : confirm_ctr - 1;
         end else if (mean > cfg_bright) begin
            confirm_ctr = (confirm_ctr < 0) ? 1 : confirm_ctr + 1;
         end else begin
            confirm_ctr = 0;
         end
         if (confirm_ctr <= -need) begin
            want_bw = 1'b1;
            confirm_ctr = 0;
         end else if (confirm_ctr >= need) begin
            want_bw = 1'b0;
            confirm_ctr = 0;
         end

         // A command goes out on a change, or until the sensor has answered once.
         if (want_bw != bw_active || !effect_probed) begin
            res.command_valid = 1'b1;
            res.command_bw = want_bw;
            if (!cfg_capable) begin
               bw_believed = 1'b0;
               bw_active = 1'b0;
               auto_owned = 1'b0;
            end else begin
               effect_probed = 1'b1;
               bw_believed = 1'b1;
               bw_active = want_bw;
               auto_owned = 1'b1;
               effects_applied++;
            end
         end
      end

      luma_acc = '0;
      frame_pixels = 0;
      frame_oversized = 1'b0;

      res.luma = last_mean;
      res.effect_bw = bw_active;
      res.gray_supported = bw_believed;
      res.sample_count = samples_done;
      res.switch_count = effects_applied;
      res.confirm_level = confirm_ctr[4:0];
      return 1'b1;
   endfunction

   // Offers one transaction, with random gaps before it, and predicts on acceptance.
   task automatic send_item(input luma_req_type it, input bit typed,
                            input tick_result_type typed_res);
      tick_result_type res;
      bit              has_result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= it.opcode;
      req_bus.red <= it.red;
      req_bus.green <= it.green;
      req_bus.blue <= it.blue;
      req_bus.frame_ok <= it.frame_ok;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      has_result = step_switch(it, res);
      if (has_result) begin
         tick_results_due.push_back(typed ? typed_res : res);
      end
      @(negedge clock);
   endtask

   // Stops the sender and waits until every pending result has come back.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (tick_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One transfer on the control port: setup cycle, then access cycle.
   task automatic csr_access(input bit is_write, input logic [2:0] idx,
                             input logic [31:0] data, output logic [31:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [31:0] csr_shadow(input logic [2:0] idx);
      case (idx)
         dnls_pkg::REG_DARK_THRESHOLD:    return 32'(cfg_dark);
         dnls_pkg::REG_BRIGHT_THRESHOLD:  return 32'(cfg_bright);
         dnls_pkg::REG_CONFIRM_NEEDED:    return 32'(cfg_confirm);
         dnls_pkg::REG_AUTO_ENABLE:       return 32'(cfg_auto);
         dnls_pkg::REG_SENSOR_BW_CAPABLE: return 32'(cfg_capable);
         default:                         return 32'd0;
      endcase
   endfunction

   // Writes a register once the block is idle, then reads it back.
   task automatic write_setting(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] rdata;
      quiesce();
      csr_access(1'b1, idx, value, rdata);
      case (idx)
         dnls_pkg::REG_DARK_THRESHOLD:    cfg_dark = value[7:0];
         dnls_pkg::REG_BRIGHT_THRESHOLD:  cfg_bright = value[7:0];
         dnls_pkg::REG_CONFIRM_NEEDED:    cfg_confirm = value[3:0];
         dnls_pkg::REG_AUTO_ENABLE:       cfg_auto = value[0];
         dnls_pkg::REG_SENSOR_BW_CAPABLE: cfg_capable = value[0];
         default: ;
      endcase
      csr_access(1'b0, idx, 32'd0, rdata);
      if (rdata !== csr_shadow(idx)) begin
         report_mismatch($sformatf("register %0d readback", idx), rdata, csr_shadow(idx));
      end
   endtask

   // Random frames: runs of frames in one brightness class, so that the
   // confirm counter actually reaches its limit, mixed with noisy frames.
   task automatic feed_frames(input int item_goal);
      luma_req_type it;
      int           fed;
      int           run_left;
      int           lum_class;
      int           npix;
      int           lo;
      int           hi;
      fed = 0;
      run_left = 0;
      lum_class = 0;
      while (fed < item_goal) begin
         if (run_left == 0) begin
            lum_class = $urandom_range(3);
            run_left = $urandom_range(1, int'(cfg_confirm) + 2);
         end
         run_left--;
         case (lum_class)
            0: begin
               lo = 0;
               hi = (cfg_dark == 0) ? 0 : int'(cfg_dark) - 1;
            end
            1: begin
               lo = (cfg_dark < cfg_bright) ? int'(cfg_dark) : int'(cfg_bright);
               hi = (cfg_dark < cfg_bright) ? int'(cfg_bright) : int'(cfg_dark);
            end
            2: begin
               lo = (cfg_bright == 255) ? 255 : int'(cfg_bright) + 1;
               hi = 255;
            end
            default: begin
               lo = 0;
               hi = 255;
            end
         endcase
         npix = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
         repeat (npix) begin
            it.opcode = dnls_pkg::OP_PIXEL;
            it.red = 8'($urandom_range(hi, lo));
            it.green = 8'($urandom_range(hi, lo));
            it.blue = 8'($urandom_range(hi, lo));
            it.frame_ok = 1'($urandom_range(1));
            send_item(it, 1'b0, NO_RESULT);
            fed++;
         end
         if ($urandom_range(29) == 0) begin
            quiesce();
         end
         // Tick payload carries junk colour bits that must be ignored.
         it.opcode = dnls_pkg::OP_TICK;
         it.red = 8'($urandom_range(255));
         it.green = 8'($urandom_range(255));
         it.blue = 8'($urandom_range(255));
         it.frame_ok = (lum_class == 3) ? 1'($urandom_range(1)) : ($urandom_range(9) != 0);
         send_item(it, 1'b0, NO_RESULT);
         fed++;
      end
   endtask

   // Receiver back-pressure.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checking against the oldest pending expectation.
   always @(posedge clock) begin : result_check
      tick_result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (tick_results_due.size() == 0) begin
            report_mismatch("result with no pending tick", 1, 0);
         end else begin
            due = tick_results_due.pop_front();
            if (rsp_bus.luma !== due.luma)
               report_mismatch("luma", rsp_bus.luma, due.luma);
            if (rsp_bus.sampled !== due.sampled)
               report_mismatch("sampled", rsp_bus.sampled, due.sampled);
            if (rsp_bus.effect_bw !== due.effect_bw)
               report_mismatch("effect_bw", rsp_bus.effect_bw, due.effect_bw);
            if (rsp_bus.command_valid !== due.command_valid)
               report_mismatch("command_valid", rsp_bus.command_valid, due.command_valid);
            if (rsp_bus.command_bw !== due.command_bw)
               report_mismatch("command_bw", rsp_bus.command_bw, due.command_bw);
            if (rsp_bus.gray_supported !== due.gray_supported)
               report_mismatch("gray_supported", rsp_bus.gray_supported,
                               due.gray_supported);
            if (rsp_bus.sample_count !== due.sample_count)
               report_mismatch("sample_count", rsp_bus.sample_count, due.sample_count);
            if (rsp_bus.switch_count !== due.switch_count)
               report_mismatch("switch_count", rsp_bus.switch_count, due.switch_count);
            if (rsp_bus.confirm_level !== due.confirm_level)
               report_mismatch("confirm_level", 5'(rsp_bus.confirm_level),
                               5'(due.confirm_level));
         end
      end
   end

   // Counts cycles in which no transaction of any kind completes.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog.
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      luma_req_type it;
      stim_row_type row;
      logic [7:0]   dk;
      logic [7:0]   br;
      int           sel;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = dnls_pkg::OP_PIXEL;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.frame_ok = 1'b0;

      // Bench copy of the reset state.
      cfg_dark = dnls_pkg::DARK_THRESHOLD_RST;
      cfg_bright = dnls_pkg::BRIGHT_THRESHOLD_RST;
      cfg_confirm = dnls_pkg::CONFIRM_NEEDED_RST;
      cfg_auto = 1'b1;
      cfg_capable = 1'b1;
      luma_acc = '0;
      frame_pixels = 0;
      frame_oversized = 1'b0;
      confirm_ctr = 0;
      bw_active = 1'b0;
      effect_probed = 1'b0;
      bw_believed = 1'b1;
      auto_owned = 1'b0;
      last_mean = '0;
      samples_done = '0;
      effects_applied = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 69;

      // Directed table.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         it.red = row.red;
         it.green = row.green;
         it.blue = row.blue;
         it.frame_ok = row.frame_ok;
         case (row.kind)
            ROW_CSR:   write_setting(row.reg_idx, 32'(row.csr_value));
            ROW_PIXEL: begin
               it.opcode = dnls_pkg::OP_PIXEL;
               send_item(it, row.typed, row.want);
            end
            default: begin
               it.opcode = dnls_pkg::OP_TICK;
               send_item(it, row.typed, row.want);
            end
         endcase
      end

      // Random part in three idling patterns, each under several settings.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 9 : 0;
         for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            sel = $urandom_range(9);
            if (sel < 7) begin
               dk = 8'($urandom_range(10, 120));
               br = 8'(int'(dk) + $urandom_range(0, 60));
            end else if (sel == 7) begin
               dk = 8'd0;
               br = 8'd255;
            end else if (sel == 8) begin
               dk = 8'd255;
               br = 8'd0;
            end else begin
               dk = 8'($urandom_range(255));
               br = 8'($urandom_range(255));
            end
            write_setting(dnls_pkg::REG_DARK_THRESHOLD, 32'(dk));
            write_setting(dnls_pkg::REG_BRIGHT_THRESHOLD, 32'(br));
            write_setting(dnls_pkg::REG_CONFIRM_NEEDED,
                          ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 3));
            write_setting(dnls_pkg::REG_AUTO_ENABLE, 32'($urandom_range(9) != 0));
            write_setting(dnls_pkg::REG_SENSOR_BW_CAPABLE, 32'($urandom_range(5) != 0));
            feed_frames(ITEMS_PER_BLOCK);
         end
      end

      quiesce();
      if (error_count == 0 && tick_results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
